FILE: design/uartrx_pkg.sv
// Shared types, constants and helper functions for the UART receive FIFO.
// Depends on nothing; every other design file but uartrx_ram imports this package.
package uartrx_pkg;

  // Buffer geometry.
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the channels.
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int CODE_W = 3;
  localparam int FILL_W = 11;
  localparam int ST_W   = 5;
  localparam int ENTRY_W = BYTE_W + ST_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Bit positions of the stored line status.
  localparam int ST_PARITY   = 0;
  localparam int ST_OVERRUN  = 1;
  localparam int ST_FRAMING  = 2;
  localparam int ST_BREAK    = 3;
  localparam int ST_OVERFLOW = 4;

  // Error codes reported on a pop.
  localparam logic [CODE_W-1:0] ERR_OK       = 3'd0;
  localparam logic [CODE_W-1:0] ERR_OVERFLOW = 3'd1;
  localparam logic [CODE_W-1:0] ERR_OVERRUN  = 3'd2;
  localparam logic [CODE_W-1:0] ERR_BREAK    = 3'd3;
  localparam logic [CODE_W-1:0] ERR_FRAMING  = 3'd4;
  localparam logic [CODE_W-1:0] ERR_PARITY   = 3'd5;

  // One request item.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
    logic              parity_err;
    logic              overrun_err;
    logic              framing_err;
    logic              break_seen;
  } uartrx_item_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [CODE_W-1:0] error_code;
    logic              was_empty;
    logic              dropped;
    logic [FILL_W-1:0] fill_count;
    logic [FILL_W-1:0] end_char_count;
  } uartrx_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;
    logic pop_start;
    logic pop_finish;
    logic pop_empty;
    logic clear;
    logic idle_op;
  } uartrx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic skid_full;
  } uartrx_stat_t;

  // Error code of a stored status, highest priority first.
  function automatic logic [CODE_W-1:0] code_of(input logic [ST_W-1:0] st);
    logic [CODE_W-1:0] code;
    if (st[ST_OVERFLOW]) begin
      code = ERR_OVERFLOW;
    end else if (st[ST_OVERRUN]) begin
      code = ERR_OVERRUN;
    end else if (st[ST_BREAK]) begin
      code = ERR_BREAK;
    end else if (st[ST_FRAMING]) begin
      code = ERR_FRAMING;
    end else if (st[ST_PARITY]) begin
      code = ERR_PARITY;
    end else begin
      code = ERR_OK;
    end
    return code;
  endfunction

  // Ring buffer index advance with wrap.
  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] i);
    return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

FILE: design/uartrx_if.sv
// Channel interfaces of the UART receive FIFO: requests, results, configuration.
// Depends on uartrx_pkg for field widths.
interface uartrx_req_if import uartrx_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] rx_byte;
  logic              parity_err;
  logic              overrun_err;
  logic              framing_err;
  logic              break_seen;

  modport source (output valid, command, rx_byte, parity_err, overrun_err,
                  framing_err, break_seen, input ready);
  modport sink (input valid, command, rx_byte, parity_err, overrun_err,
                framing_err, break_seen, output ready);
endinterface

interface uartrx_rsp_if import uartrx_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [CODE_W-1:0] error_code;
  logic              was_empty;
  logic              dropped;
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] end_char_count;

  modport source (output valid, data_byte, error_code, was_empty, dropped,
                  fill_count, end_char_count, input ready);
  modport sink (input valid, data_byte, error_code, was_empty, dropped,
                fill_count, end_char_count, output ready);
endinterface

interface uartrx_cfg_if import uartrx_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] eot_char;

  modport source (output valid, eot_char, input ready);
  modport sink (input valid, eot_char, output ready);
endinterface

FILE: design/uartrx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module uartrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/uartrx_ctrl.sv
// Controller of the UART receive FIFO: accepts requests and sequences pops.
// Depends on uartrx_pkg for command codes and the command/status structs.
module uartrx_ctrl import uartrx_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] command,
  input  uartrx_stat_t     stat,
  output uartrx_cmd_t      cmd
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_READ = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       accept;

  // A request is taken only when idle and a result slot is free.
  assign in_ready = (state == S_IDLE) && !stat.skid_full;
  assign accept   = in_valid && in_ready;

  // Decode the request and step the state machine.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_PUSH: begin
              cmd.push = 1'b1;
            end
            CMD_POP: begin
              if (stat.empty) begin
                cmd.pop_empty = 1'b1;
              end else begin
                cmd.pop_start = 1'b1;
                state_next    = S_READ;
              end
            end
            CMD_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
              cmd.idle_op = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.pop_finish = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/uartrx_dp.sv
// Datapath of the UART receive FIFO: indexes, counters, entry RAM, result queue.
// Depends on uartrx_pkg and instantiates uartrx_ram.
module uartrx_dp import uartrx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  uartrx_item_t      item,
  input  uartrx_cmd_t       cmd,
  input  logic              cfg_valid,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output uartrx_res_t       out_res,
  output uartrx_stat_t      stat
);

  logic [ADDR_W-1:0]  write_index, write_index_next;
  logic [ADDR_W-1:0]  read_index, read_index_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [CNT_W-1:0]   end_count, end_count_next;
  logic               previous_break, previous_break_next;
  logic [BYTE_W-1:0]  eot_char;

  logic               full;
  logic               rep_break;
  logic               push_store;
  logic [ST_W-1:0]    st_in;
  logic [ENTRY_W-1:0] rd_data;
  logic [BYTE_W-1:0]  rd_char;
  logic [ST_W-1:0]    rd_st;

  uartrx_res_t        res;
  logic               res_load;
  uartrx_res_t        skid_res;
  logic               skid_valid;
  logic               out_free;

  // Push qualification: repeated break or a full buffer drops the byte.
  assign full       = (entry_count == CNT_W'(DEPTH));
  assign rep_break  = item.break_seen && previous_break;
  assign push_store = cmd.push && !rep_break && !full;

  // The entry that fills the buffer carries the overflow mark.
  assign st_in = {entry_count == CNT_W'(DEPTH - 1), item.break_seen,
                  item.framing_err, item.overrun_err, item.parity_err};

  uartrx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_store),
    .waddr (write_index),
    .wdata ({item.rx_byte, st_in}),
    .raddr (read_index),
    .rdata (rd_data)
  );

  assign rd_char = rd_data[ST_W +: BYTE_W];
  assign rd_st   = rd_data[ST_W-1:0];

  // Next values of indexes, counters and the break history.
  always_comb begin
    write_index_next    = write_index;
    read_index_next     = read_index;
    entry_count_next    = entry_count;
    end_count_next      = end_count;
    previous_break_next = previous_break;
    if (cmd.push) begin
      previous_break_next = item.break_seen;
      if (push_store) begin
        entry_count_next = entry_count + 1'b1;
        if (item.rx_byte == eot_char && end_count != CNT_W'(DEPTH)) begin
          end_count_next = end_count + 1'b1;
        end
        write_index_next = next_slot(write_index);
      end
    end
    if (cmd.pop_finish) begin
      entry_count_next = entry_count - 1'b1;
      if (rd_char == eot_char && end_count != '0) begin
        end_count_next = end_count - 1'b1;
      end
      read_index_next = next_slot(read_index);
    end
    if (cmd.clear) begin
      previous_break_next = 1'b0;
      end_count_next      = '0;
      entry_count_next    = '0;
      read_index_next     = write_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      read_index     <= '0;
      entry_count    <= '0;
      end_count      <= '0;
      previous_break <= 1'b0;
      eot_char       <= '0;
    end else begin
      write_index    <= write_index_next;
      read_index     <= read_index_next;
      entry_count    <= entry_count_next;
      end_count      <= end_count_next;
      previous_break <= previous_break_next;
      if (cfg_valid) begin
        eot_char <= cfg_data;
      end
    end
  end

  // Result of the current step, built from the updated counts.
  always_comb begin
    res.data_byte      = cmd.pop_finish ? rd_char : '0;
    res.error_code     = cmd.pop_finish ? code_of(rd_st) : ERR_OK;
    res.was_empty      = cmd.pop_empty;
    res.dropped        = cmd.push && !push_store;
    res.fill_count     = FILL_W'(entry_count_next);
    res.end_char_count = FILL_W'(end_count_next);
  end

  assign res_load = cmd.push || cmd.pop_finish || cmd.pop_empty || cmd.clear ||
                    cmd.idle_op;

  // Two-slot result queue: output register plus a skid register.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_load;
      end else begin
        out_valid  <= res_load;
      end
    end else if (res_load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res  <= skid_res;
        skid_res <= res;
      end else begin
        out_res  <= res;
      end
    end else if (res_load) begin
      skid_res <= res;
    end
  end

  assign stat.empty     = (entry_count == '0);
  assign stat.skid_full = skid_valid;

endmodule

FILE: design/uart_receive_fifo_with_status.sv
// UART receive FIFO with per-entry line status. Each push stores a received byte
// with its parity, overrun, framing and break flags in a ring buffer of DEPTH
// entries (uartrx_pkg); each pop returns the oldest byte and one prioritized
// error code, and every request yields exactly one result with the fill count
// and the count of stored end characters (eot_char, set on the cfg channel).
// Push, clear, the unused command and an empty pop are served in the idle state;
// a pop that finds an entry also passes the read state, for the registered read
// of the entry RAM. Two results can wait at the output, so a request is still
// taken while one result stalls. No clearing pass is needed after reset.
// Depends on uartrx_pkg, uartrx_if, uartrx_ctrl and uartrx_dp.
module uart_receive_fifo_with_status import uartrx_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  uartrx_req_if.sink   req,
  uartrx_rsp_if.source rsp,
  uartrx_cfg_if.sink   cfg
);

  uartrx_item_t item;
  uartrx_cmd_t  cmd;
  uartrx_stat_t stat;
  uartrx_res_t  res;

  // Gather the request payload.
  assign item.command     = req.command;
  assign item.rx_byte     = req.rx_byte;
  assign item.parity_err  = req.parity_err;
  assign item.overrun_err = req.overrun_err;
  assign item.framing_err = req.framing_err;
  assign item.break_seen  = req.break_seen;

  // The configuration register is always writable.
  assign cfg.ready = 1'b1;

  uartrx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .command  (req.command),
    .stat     (stat),
    .cmd      (cmd)
  );

  uartrx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.eot_char),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .out_res   (res),
    .stat      (stat)
  );

  // Spread the result onto the response channel.
  assign rsp.data_byte      = res.data_byte;
  assign rsp.error_code     = res.error_code;
  assign rsp.was_empty      = res.was_empty;
  assign rsp.dropped        = res.dropped;
  assign rsp.fill_count     = res.fill_count;
  assign rsp.end_char_count = res.end_char_count;

endmodule

FILE: design/uartrx_chk.sv
// Port-level checker for the UART receive FIFO, attached by a bind statement.
// Depends on uartrx_pkg and on the top level uart_receive_fifo_with_status.
module uartrx_chk import uartrx_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [BYTE_W-1:0] data_byte,
  input logic [CODE_W-1:0] error_code,
  input logic              was_empty,
  input logic              dropped,
  input logic [FILL_W-1:0] fill_count
);

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // A dropped push reports no data, no error and no empty pop.
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && dropped |-> data_byte == '0 && error_code == ERR_OK && !was_empty)
    else $error("dropped push carries pop fields");

  // A pop that found nothing leaves the buffer empty.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && was_empty |-> fill_count == '0 && !dropped && data_byte == '0)
    else $error("empty pop with nonzero fill count");

  // Error codes stay within the defined set.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> error_code <= ERR_PARITY)
    else $error("undefined error code");

endmodule

bind uart_receive_fifo_with_status uartrx_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .data_byte  (rsp.data_byte),
  .error_code (rsp.error_code),
  .was_empty  (rsp.was_empty),
  .dropped    (rsp.dropped),
  .fill_count (rsp.fill_count)
);
